// ----- design/sensor_monitor_moving_average_defines.svh -----
// ----------------------------------------------------------------------------
// sensor_monitor_moving_average_defines.svh
// Assertion macros shared by the sensor supervisor RTL.
// ----------------------------------------------------------------------------
`ifndef SENSOR_MONITOR_MOVING_AVERAGE_DEFINES_SVH
`define SENSOR_MONITOR_MOVING_AVERAGE_DEFINES_SVH

// Plain implication, sampled on clk, off while arst_n is low.
`define SMMA_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check on every cycle a result is presented.
`define SMMA_ASSERT_RESULT(label, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) result_valid |-> (cons)) \
		else $error(msg);

`endif

// ----- design/smma_pkg.sv -----
// ----------------------------------------------------------------------------
// smma_pkg
// Shared constants, codes and types of the sensor supervisor.
// ----------------------------------------------------------------------------
package smma_pkg;

	localparam int WINDOW      = 150;
	localparam int SAMPLE_BITS = 12;

	localparam int FULL_SCALE = (1 << SAMPLE_BITS) - 1;
	localparam int MV_SPAN    = 3300;
	localparam int MV_BITS    = 12;
	localparam int SPAN_W     = $clog2(MV_SPAN + 1);

	localparam int THRESH_W = 12;
	localparam int DWELL_W  = 16;
	localparam int TIME_W   = 32;
	localparam int CMP_W    = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

	localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W = $clog2(WINDOW * FULL_SCALE + 1);

	// floor(x / d) = (x * M) >> S for every x below 2^N,
	// with S = N + ceil(log2 d) and M = ceil(2^S / d).
	localparam int              AVG_L   = $clog2(WINDOW);
	localparam int              AVG_S   = SUM_W + AVG_L;
	localparam longint unsigned AVG_M   = ((64'd1 << AVG_S) + WINDOW - 1) / WINDOW;
	localparam int              AVG_M_W = SUM_W + 1;
	localparam int              AVG_P_W = SUM_W + AVG_M_W;

	localparam int              PROD_W = SAMPLE_BITS + SPAN_W;
	localparam int              FS_L   = $clog2(FULL_SCALE);
	localparam int              FS_S   = PROD_W + FS_L;
	localparam longint unsigned FS_M   = ((64'd1 << FS_S) + FULL_SCALE - 1) / FULL_SCALE;
	localparam int              FS_M_W = PROD_W + 1;
	localparam int              FS_P_W = PROD_W + FS_M_W;

	// APB register map
	localparam int DATA_W = 32;
	localparam int ADDR_W = 4;

	typedef enum logic [1:0] {
		REG_WARN   = 2'd0,
		REG_ERROR  = 2'd1,
		REG_DWELL  = 2'd2,
		REG_REPORT = 2'd3
	} reg_idx_t;

	localparam logic [THRESH_W-1:0] WARN_RESET  = THRESH_W'(2000);
	localparam logic [THRESH_W-1:0] ERROR_RESET = THRESH_W'(3000);
	localparam logic [DWELL_W-1:0]  DWELL_RESET = DWELL_W'(5000);

	typedef enum logic [2:0] {
		ST_WAIT   = 3'd0,
		ST_LISTEN = 3'd1,
		ST_PAUSE  = 3'd2,
		ST_WARN   = 3'd3,
		ST_ERROR  = 3'd4
	} ctrl_state_t;

	typedef struct packed {
		logic [THRESH_W-1:0] warn_threshold;
		logic [THRESH_W-1:0] error_threshold;
		logic [DWELL_W-1:0]  dwell_ms;
		logic                report_select;
	} cfg_t;

	// committed step, handed to the millivolt pipeline
	typedef struct packed {
		ctrl_state_t            state;
		logic                   taken;
		logic [SAMPLE_BITS-1:0] raw;
		logic [SUM_W-1:0]       sum;
	} commit_t;

endpackage

// ----- design/sensor_monitor_moving_average.sv -----
// ----------------------------------------------------------------------------
// sensor_monitor_moving_average
// Sensor supervisor: control state machine, boxcar average over a sample
// ring, warning dwell timer and millivolt reporting.
// ----------------------------------------------------------------------------
// Takes one item (sample or button press) per clock while the output is
// not stalled and returns one result per item. Rate is set by the ring
// memory's read-modify-write: the entry under the pointer is read at
// transfer and rewritten when the step commits; a read of the entry being
// written in that cycle is forwarded. After the commit, three pipelined
// stages form the average and the millivolt values by constant
// multiplies. Per-entry valid bits give
// the zeroed ring after reset and after a press in error, with no clearing
// pass. Configuration goes through the APB port at byte addresses 0, 4, 8
// and 12 and should be written only while no item is in flight.
// ----------------------------------------------------------------------------
module sensor_monitor_moving_average (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [smma_pkg::ADDR_W-1:0]       paddr,
	input  logic [smma_pkg::DATA_W-1:0]       pwdata,
	output logic [smma_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,

	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic                              mode,
	input  logic [smma_pkg::SAMPLE_BITS-1:0]  sample,
	input  logic [smma_pkg::TIME_W-1:0]       now_ms,

	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [2:0]                        ctrl_state,
	output logic                              sample_taken,
	output logic [smma_pkg::MV_BITS-1:0]      raw_mv,
	output logic [smma_pkg::MV_BITS-1:0]      average_mv,
	output logic [smma_pkg::MV_BITS-1:0]      report_mv
);

	smma_pkg::cfg_t    cfg;
	smma_pkg::commit_t res;
	logic              res_valid;
	logic              advance;

	smma_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	smma_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.mode       (mode),
		.sample     (sample),
		.now_ms     (now_ms),
		.cfg        (cfg),
		.res_valid  (res_valid),
		.res        (res)
	);

	smma_scale u_scale (
		.clk           (clk),
		.arst_n        (arst_n),
		.res_valid     (res_valid),
		.res           (res),
		.report_select (cfg.report_select),
		.advance       (advance),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.ctrl_state    (ctrl_state),
		.sample_taken  (sample_taken),
		.raw_mv        (raw_mv),
		.average_mv    (average_mv),
		.report_mv     (report_mv)
	);

`include "sensor_monitor_moving_average_defines.svh"

	`SMMA_ASSERT_RESULT(a_idle_mv_zero, sample_taken || (raw_mv == '0 && average_mv == '0 && report_mv == '0), "mV fields nonzero without a sample")
	`SMMA_ASSERT_RESULT(a_mv_range, raw_mv <= smma_pkg::MV_SPAN && average_mv <= smma_pkg::MV_SPAN, "mV value above full span")
	`SMMA_ASSERT_IMPLY(a_taken_state, result_valid && sample_taken, ctrl_state == smma_pkg::ST_LISTEN || ctrl_state == smma_pkg::ST_WARN || ctrl_state == smma_pkg::ST_ERROR, "sample taken outside listening")

endmodule

// ----- design/smma_cfg.sv -----
// ----------------------------------------------------------------------------
// smma_cfg
// APB register file: thresholds, dwell time and report source.
// ----------------------------------------------------------------------------
module smma_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [smma_pkg::ADDR_W-1:0]   paddr,
	input  logic [smma_pkg::DATA_W-1:0]   pwdata,
	output logic [smma_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output smma_pkg::cfg_t                cfg
);

	smma_pkg::cfg_t   cfg_q;
	smma_pkg::reg_idx_t idx;
	logic             wr_en;

	assign pready = 1'b1;
	assign idx    = smma_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.warn_threshold  <= smma_pkg::WARN_RESET;
			cfg_q.error_threshold <= smma_pkg::ERROR_RESET;
			cfg_q.dwell_ms        <= smma_pkg::DWELL_RESET;
			cfg_q.report_select   <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				smma_pkg::REG_WARN:   cfg_q.warn_threshold  <= pwdata[smma_pkg::THRESH_W-1:0];
				smma_pkg::REG_ERROR:  cfg_q.error_threshold <= pwdata[smma_pkg::THRESH_W-1:0];
				smma_pkg::REG_DWELL:  cfg_q.dwell_ms        <= pwdata[smma_pkg::DWELL_W-1:0];
				smma_pkg::REG_REPORT: cfg_q.report_select   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			smma_pkg::REG_WARN:   prdata[smma_pkg::THRESH_W-1:0] = cfg_q.warn_threshold;
			smma_pkg::REG_ERROR:  prdata[smma_pkg::THRESH_W-1:0] = cfg_q.error_threshold;
			smma_pkg::REG_DWELL:  prdata[smma_pkg::DWELL_W-1:0]  = cfg_q.dwell_ms;
			smma_pkg::REG_REPORT: prdata[0]                      = cfg_q.report_select;
			default: ;
		endcase
	end

endmodule

// ----- design/smma_core.sv -----
// ----------------------------------------------------------------------------
// smma_core
// Ring memory, running sum and control state machine. The ring entry is
// read at transfer and rewritten when the step commits.
// ----------------------------------------------------------------------------
module smma_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               advance,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic                               mode,
	input  logic [smma_pkg::SAMPLE_BITS-1:0]   sample,
	input  logic [smma_pkg::TIME_W-1:0]        now_ms,
	input  smma_pkg::cfg_t                     cfg,
	output logic                               res_valid,
	output smma_pkg::commit_t                  res
);

	localparam int B = smma_pkg::SAMPLE_BITS;
	localparam int P = smma_pkg::PTR_W;
	localparam int S = smma_pkg::SUM_W;
	localparam int T = smma_pkg::TIME_W;
	localparam int C = smma_pkg::CMP_W;

	// ring storage, no reset; per-entry valid bits stand in for the zero fill
	logic [B-1:0]               ring_mem [smma_pkg::WINDOW];
	logic [B-1:0]               rd_data_q;
	logic [smma_pkg::WINDOW-1:0] valid_q;

	// architectural state
	smma_pkg::ctrl_state_t state_q;
	logic [P-1:0]          ptr_q;
	logic [S-1:0]          sum_q;
	logic                  armed_q;
	logic [T-1:0]          start_q;

	// stage 1: item waiting for its ring read
	logic         valid_s1;
	logic         mode_s1;
	logic [B-1:0] sample_s1;
	logic [T-1:0] now_s1;
	logic         fwd_s1;
	logic [B-1:0] fwd_data_s1;

	// stage 2: committed result
	logic              valid_s2;
	smma_pkg::commit_t res_s2;

	logic                  accept, commit;
	logic [P-1:0]          rd_addr;
	logic [B-1:0]          old_val;
	logic [S-1:0]          sum_new;
	logic [T-1:0]          elapsed;
	logic                  dwell_hit, over_err, over_warn;
	logic                  clear, wr_en, taken;
	smma_pkg::ctrl_state_t state_d;
	logic [P-1:0]          ptr_d;
	logic [S-1:0]          sum_d;
	logic                  armed_d;
	logic [T-1:0]          start_d;
	smma_pkg::commit_t     res_d;

	assign accept     = item_valid && advance;
	assign commit     = valid_s1 && advance;
	assign item_stall = !advance;

	always_comb begin
		old_val   = fwd_s1 ? fwd_data_s1 : (valid_q[ptr_q] ? rd_data_q : '0);
		sum_new   = sum_q - S'(old_val) + S'(sample_s1);
		elapsed   = now_s1 - start_q;
		dwell_hit = elapsed >= T'(cfg.dwell_ms);
		over_err  = C'(sample_s1) > C'(cfg.error_threshold);
		over_warn = C'(sample_s1) > C'(cfg.warn_threshold);

		state_d = state_q;
		ptr_d   = ptr_q;
		sum_d   = sum_q;
		armed_d = armed_q;
		start_d = start_q;
		clear   = 1'b0;
		wr_en   = 1'b0;
		taken   = 1'b0;

		if (mode_s1) begin
			unique case (state_q)
				smma_pkg::ST_WAIT:   state_d = smma_pkg::ST_LISTEN;
				smma_pkg::ST_LISTEN: state_d = smma_pkg::ST_PAUSE;
				smma_pkg::ST_PAUSE:  state_d = smma_pkg::ST_LISTEN;
				smma_pkg::ST_WARN:   state_d = smma_pkg::ST_WAIT;
				default: begin
					// press in error: back to reset values
					clear   = 1'b1;
					state_d = smma_pkg::ST_WAIT;
					ptr_d   = '0;
					sum_d   = '0;
					armed_d = 1'b0;
					start_d = '0;
				end
			endcase
		end else if (state_q == smma_pkg::ST_LISTEN) begin
			taken = 1'b1;
			wr_en = 1'b1;
			sum_d = sum_new;
			ptr_d = (ptr_q == P'(smma_pkg::WINDOW - 1)) ? '0 : ptr_q + P'(1);
			priority if (over_err) begin
				state_d = smma_pkg::ST_ERROR;
			end else if (over_warn) begin
				if (!armed_q) begin
					armed_d = 1'b1;
					start_d = now_s1;
				end else if (dwell_hit) begin
					armed_d = 1'b0;
					state_d = smma_pkg::ST_WARN;
				end
			end else begin
				armed_d = 1'b0;
			end
		end

		res_d.state = state_d;
		res_d.taken = taken;
		res_d.raw   = taken ? sample_s1 : '0;
		res_d.sum   = taken ? sum_new : '0;
	end

	// a transfer in the commit cycle reads where the pointer is heading
	assign rd_addr = commit ? ptr_d : ptr_q;

	always_ff @(posedge clk) begin
		if (commit && wr_en) begin
			ring_mem[ptr_q] <= sample_s1;
		end
		if (accept) begin
			rd_data_q <= ring_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			state_q  <= smma_pkg::ST_WAIT;
			ptr_q    <= '0;
			sum_q    <= '0;
			armed_q  <= 1'b0;
			start_q  <= '0;
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (commit) begin
				state_q <= state_d;
				ptr_q   <= ptr_d;
				sum_q   <= sum_d;
				armed_q <= armed_d;
				start_q <= start_d;
				if (clear) begin
					valid_q <= '0;
				end else if (wr_en) begin
					valid_q[ptr_q] <= 1'b1;
				end
			end
			if (advance) begin
				valid_s1 <= item_valid;
				valid_s2 <= valid_s1;
				// same entry written while it is read: take the new value
				fwd_s1   <= accept && commit && wr_en && (rd_addr == ptr_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1     <= mode;
			sample_s1   <= sample;
			now_s1      <= now_ms;
			fwd_data_s1 <= sample_s1;
		end
		if (commit) begin
			res_s2 <= res_d;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

endmodule

// ----- design/smma_scale.sv -----
// ----------------------------------------------------------------------------
// smma_scale
// Boxcar average and millivolt conversion pipeline with the result register.
// ----------------------------------------------------------------------------
module smma_scale (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              res_valid,
	input  smma_pkg::commit_t                 res,
	input  logic                              report_select,
	output logic                              advance,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [2:0]                        ctrl_state,
	output logic                              sample_taken,
	output logic [smma_pkg::MV_BITS-1:0]      raw_mv,
	output logic [smma_pkg::MV_BITS-1:0]      average_mv,
	output logic [smma_pkg::MV_BITS-1:0]      report_mv
);

	localparam int B   = smma_pkg::SAMPLE_BITS;
	localparam int PW  = smma_pkg::PROD_W;
	localparam int APW = smma_pkg::AVG_P_W;
	localparam int FPW = smma_pkg::FS_P_W;
	localparam int MVB = smma_pkg::MV_BITS;

	logic [APW-1:0] avg_full;
	logic [FPW-1:0] raw_full, avg_mv_full;

	// stage 3: average, raw product
	logic                  valid_s3, taken_s3;
	smma_pkg::ctrl_state_t state_s3;
	logic [B-1:0]          avg_s3;
	logic [PW-1:0]         raw_prod_s3;

	// stage 4: average product, raw millivolts
	logic                  valid_s4, taken_s4;
	smma_pkg::ctrl_state_t state_s4;
	logic [PW-1:0]         avg_prod_s4;
	logic [MVB-1:0]        raw_mv_s4;

	// result register
	logic                  out_valid_q, taken_q;
	smma_pkg::ctrl_state_t state_q;
	logic [MVB-1:0]        raw_mv_q, avg_mv_q;

	assign advance = !(out_valid_q && result_stall);

	assign avg_full    = APW'(res.sum) * APW'(smma_pkg::AVG_M);
	assign raw_full    = FPW'(raw_prod_s3) * FPW'(smma_pkg::FS_M);
	assign avg_mv_full = FPW'(avg_prod_s4) * FPW'(smma_pkg::FS_M);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s3    <= res_valid;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			state_s3    <= res.state;
			taken_s3    <= res.taken;
			avg_s3      <= B'(avg_full >> smma_pkg::AVG_S);
			raw_prod_s3 <= PW'(res.raw) * PW'(smma_pkg::MV_SPAN);

			state_s4    <= state_s3;
			taken_s4    <= taken_s3;
			avg_prod_s4 <= PW'(avg_s3) * PW'(smma_pkg::MV_SPAN);
			raw_mv_s4   <= MVB'(raw_full >> smma_pkg::FS_S);

			state_q  <= state_s4;
			taken_q  <= taken_s4;
			raw_mv_q <= raw_mv_s4;
			avg_mv_q <= MVB'(avg_mv_full >> smma_pkg::FS_S);
		end
	end

	assign result_valid = out_valid_q;
	assign ctrl_state   = state_q;
	assign sample_taken = taken_q;
	assign raw_mv       = raw_mv_q;
	assign average_mv   = avg_mv_q;
	assign report_mv    = report_select ? avg_mv_q : raw_mv_q;

endmodule

// ----- verif/sensor_monitor_moving_average_test.sv -----
// ----------------------------------------------------------------------------
// sensor_monitor_moving_average_test
// Self-checking bench for the sensor supervisor. A directed table walks the
// control states, thresholds, dwell timing (timestamp wrap included) and the
// clear on a press in error. Random phases follow, one per register setting,
// with level runs that hold the sensor high, low or past the error level.
// Every result transfer is compared field by field with a local predictor,
// and each register write is read back.
// ----------------------------------------------------------------------------
module sensor_monitor_moving_average_test;
	import smma_pkg::*;

	localparam bit          MODE_SAMPLE     = 1'b0;
	localparam bit          MODE_PRESS      = 1'b1;
	localparam int          PHASES          = 7;
	localparam int          ITEMS_PER_PHASE = 200;
	localparam int unsigned WATCHDOG_LIMIT  = 4000;

	typedef struct {
		ctrl_state_t        state;
		bit                 taken;
		logic [MV_BITS-1:0] raw_mv;
		logic [MV_BITS-1:0] avg_mv;
		logic [MV_BITS-1:0] rep_mv;
	} reading_t;

	typedef struct {
		bit                     m;
		logic [SAMPLE_BITS-1:0] s;
		logic [TIME_W-1:0]      t;
		bit                     known;
		reading_t               want;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [ADDR_W-1:0]      paddr = '0;
	logic [DATA_W-1:0]      pwdata = '0;
	logic [DATA_W-1:0]      prdata;
	logic                   pready;
	logic                   item_valid = 1'b0;
	logic                   item_stall;
	logic                   mode = 1'b0;
	logic [SAMPLE_BITS-1:0] sample = '0;
	logic [TIME_W-1:0]      now_ms = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	logic [2:0]             ctrl_state;
	logic                   sample_taken;
	logic [MV_BITS-1:0]     raw_mv;
	logic [MV_BITS-1:0]     average_mv;
	logic [MV_BITS-1:0]     report_mv;

	sensor_monitor_moving_average dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item_valid(item_valid), .item_stall(item_stall),
		.mode(mode), .sample(sample), .now_ms(now_ms),
		.result_valid(result_valid), .result_stall(result_stall),
		.ctrl_state(ctrl_state), .sample_taken(sample_taken),
		.raw_mv(raw_mv), .average_mv(average_mv), .report_mv(report_mv)
	);

	always #6 clk = ~clk;

	// supervisor model: registers and state
	logic [THRESH_W-1:0]    cfg_warn = WARN_RESET;
	logic [THRESH_W-1:0]    cfg_error = ERROR_RESET;
	logic [DWELL_W-1:0]     cfg_dwell = DWELL_RESET;
	bit                     cfg_report = 1'b0;
	logic [SAMPLE_BITS-1:0] sample_history [WINDOW];
	int unsigned            history_ptr;
	int unsigned            window_sum;
	ctrl_state_t            sup_state;
	bit                     dwell_armed;
	logic [TIME_W-1:0]      dwell_since;

	reading_t    pending_readings [$];
	stim_row_t   directed_rows [$];
	int unsigned fault_count = 0;
	int unsigned quiet_cycles = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;

	// random level runs
	int unsigned       level_kind = 0;
	int unsigned       level_left = 0;
	logic [TIME_W-1:0] clock_ms = '0;
	int unsigned       step_max = 100;

	task automatic flag(string msg);
		fault_count++;
		$display("%0t %s", $time, msg);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			flag($sformatf("%s: got %0d, expected %0d", name, got, want));
	endtask

	function automatic reading_t quiet(ctrl_state_t st);
		reading_t r;
		r.state  = st;
		r.taken  = 1'b0;
		r.raw_mv = '0;
		r.avg_mv = '0;
		r.rep_mv = '0;
		return r;
	endfunction

	function automatic void clear_supervisor();
		foreach (sample_history[i])
			sample_history[i] = '0;
		history_ptr = 0;
		window_sum  = 0;
		sup_state   = ST_WAIT;
		dwell_armed = 1'b0;
		dwell_since = '0;
	endfunction

	function automatic logic [MV_BITS-1:0] to_millivolts(int unsigned v);
		return MV_BITS'((v * MV_SPAN) / FULL_SCALE);
	endfunction

	function automatic reading_t supervise_step(bit m, logic [SAMPLE_BITS-1:0] s,
			logic [TIME_W-1:0] t);
		reading_t          r;
		logic [TIME_W-1:0] elapsed;
		r = quiet(ST_WAIT);
		if (m == MODE_PRESS) begin
			case (sup_state)
				ST_WAIT:   sup_state = ST_LISTEN;
				ST_LISTEN: sup_state = ST_PAUSE;
				ST_PAUSE:  sup_state = ST_LISTEN;
				ST_WARN:   sup_state = ST_WAIT;
				default:   clear_supervisor();
			endcase
		end else if (sup_state == ST_LISTEN) begin
			window_sum = window_sum - sample_history[history_ptr] + s;
			sample_history[history_ptr] = s;
			history_ptr = (history_ptr == WINDOW - 1) ? 0 : history_ptr + 1;
			r.taken  = 1'b1;
			r.raw_mv = to_millivolts(s);
			r.avg_mv = to_millivolts(window_sum / WINDOW);
			r.rep_mv = cfg_report ? r.avg_mv : r.raw_mv;
			// error wins over the dwell timer
			if (s > cfg_error) begin
				sup_state = ST_ERROR;
			end else if (s > cfg_warn) begin
				elapsed = t - dwell_since;
				if (!dwell_armed) begin
					dwell_armed = 1'b1;
					dwell_since = t;
				end else if (elapsed >= cfg_dwell) begin
					dwell_armed = 1'b0;
					sup_state   = ST_WARN;
				end
			end else begin
				dwell_armed = 1'b0;
			end
		end
		r.state = sup_state;
		return r;
	endfunction

	task automatic add_row(bit m, logic [SAMPLE_BITS-1:0] s, logic [TIME_W-1:0] t);
		stim_row_t row;
		row.m     = m;
		row.s     = s;
		row.t     = t;
		row.known = 1'b0;
		row.want  = quiet(ST_WAIT);
		directed_rows.push_back(row);
	endtask

	task automatic add_known(bit m, logic [SAMPLE_BITS-1:0] s, logic [TIME_W-1:0] t,
			reading_t want);
		stim_row_t row;
		row.m     = m;
		row.s     = s;
		row.t     = t;
		row.known = 1'b1;
		row.want  = want;
		directed_rows.push_back(row);
	endtask

	// write, then read back through the same select
	task automatic program_register(reg_idx_t idx, logic [31:0] value);
		logic [DATA_W-1:0] held;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_WARN:  cfg_warn = value[THRESH_W-1:0];
			REG_ERROR: cfg_error = value[THRESH_W-1:0];
			REG_DWELL: cfg_dwell = value[DWELL_W-1:0];
			default:   cfg_report = value[0];
		endcase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_WARN:  held = DATA_W'(cfg_warn);
			REG_ERROR: held = DATA_W'(cfg_error);
			REG_DWELL: held = DATA_W'(cfg_dwell);
			default:   held = DATA_W'(cfg_report);
		endcase
		check_field($sformatf("readback of register %s", idx.name()), prdata, held);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_settings(int phase);
		logic [31:0] w, e, d, r;
		case (phase)
			1:       begin w = 0;    e = 4095; d = 0;     r = 1; end
			2:       begin w = 4095; e = 4095; d = 65535; r = 0; end
			3:       begin w = 0;    e = 0;    d = 65535; r = 1; end
			4:       begin w = 1500; e = 2500; d = 300;   r = 1; end
			5:       begin w = 3000; e = 1000; d = 1000;  r = 0; end
			// full 32-bit values: upper bits must be dropped
			default: begin w = $urandom(); e = $urandom(); d = $urandom(); r = $urandom(); end
		endcase
		program_register(REG_WARN, w);
		program_register(REG_ERROR, e);
		program_register(REG_DWELL, d);
		program_register(REG_REPORT, r);
	endtask

	task automatic send_item(bit m, logic [SAMPLE_BITS-1:0] s, logic [TIME_W-1:0] t,
			bit known, reading_t want);
		reading_t guess;
		item_valid <= 1'b1;
		mode       <= m;
		sample     <= s;
		now_ms     <= t;
		do @(posedge clk); while (item_stall);
		guess = supervise_step(m, s, t);
		pending_readings.push_back(known ? want : guess);
	endtask

	task automatic next_random_item(output bit m, output logic [SAMPLE_BITS-1:0] s,
			output logic [TIME_W-1:0] t);
		int unsigned lo, hi;
		if (level_left == 0) begin
			level_kind = $urandom_range(0, 99);
			level_left = $urandom_range(1, 60);
		end
		level_left--;
		if ($urandom_range(0, 32) == 0)
			clock_ms = $urandom();
		else
			clock_ms = clock_ms + $urandom_range(0, step_max);
		t = clock_ms;
		if (sup_state != ST_LISTEN)
			m = ($urandom_range(0, 99) < 60) ? MODE_PRESS : MODE_SAMPLE;
		else
			m = ($urandom_range(0, 99) < 4) ? MODE_PRESS : MODE_SAMPLE;
		if (level_kind < 45) begin
			// band between the two thresholds
			lo = cfg_warn + 1;
			hi = cfg_error;
			if (lo > hi)
				hi = FULL_SCALE;
			if (lo > hi)
				lo = 0;
		end else if (level_kind < 75) begin
			lo = 0;
			hi = cfg_warn;
		end else if (level_kind < 85) begin
			lo = (cfg_error < FULL_SCALE) ? cfg_error + 1 : FULL_SCALE;
			hi = FULL_SCALE;
		end else begin
			lo = 0;
			hi = FULL_SCALE;
		end
		s = SAMPLE_BITS'($urandom_range(lo, hi));
	endtask

	always @(posedge clk) begin : result_check
		reading_t want;
		if (arst_n) begin
			quiet_cycles <= ((item_valid && !item_stall) || (result_valid && !result_stall))
				? 0 : quiet_cycles + 1;
			if (result_valid && !result_stall) begin
				if (pending_readings.size() == 0) begin
					flag("result transfer with nothing pending");
				end else begin
					want = pending_readings.pop_front();
					check_field("ctrl_state", ctrl_state, want.state);
					check_field("sample_taken", sample_taken, want.taken);
					check_field("raw_mv", raw_mv, want.raw_mv);
					check_field("average_mv", average_mv, want.avg_mv);
					check_field("report_mv", report_mv, want.rep_mv);
				end
			end
			result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	initial begin : watchdog
		wait (arst_n);
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		bit                     m;
		logic [SAMPLE_BITS-1:0] s;
		logic [TIME_W-1:0]      t;
		int unsigned            sent_items;
		reading_t               zero_listen;

		clear_supervisor();
		zero_listen = quiet(ST_LISTEN);
		zero_listen.taken = 1'b1;

		add_known(MODE_SAMPLE, 12'hFFF, 32'hFFFF_FFFF, quiet(ST_WAIT)); // ignored in wait
		add_known(MODE_PRESS, 12'h000, 32'd0, quiet(ST_LISTEN));
		add_known(MODE_SAMPLE, 12'd0, 32'd0, zero_listen);
		add_row(MODE_SAMPLE, 12'd2000, 32'd50);          // at warn level: not high
		add_row(MODE_SAMPLE, 12'd2001, 32'd100);         // arms dwell
		add_row(MODE_SAMPLE, 12'd2500, 32'd5099);        // one ms short
		add_row(MODE_SAMPLE, 12'd3000, 32'd5100);        // at error level, dwell done
		add_known(MODE_SAMPLE, 12'd1000, 32'd5200, quiet(ST_WARN));
		add_known(MODE_PRESS, 12'h000, 32'd0, quiet(ST_WAIT));
		add_known(MODE_PRESS, 12'h000, 32'd0, quiet(ST_LISTEN));
		add_row(MODE_SAMPLE, 12'd2100, 32'hFFFF_F000);
		add_known(MODE_PRESS, 12'h000, 32'd0, quiet(ST_PAUSE));
		add_known(MODE_SAMPLE, 12'd2200, 32'd0, quiet(ST_PAUSE));
		add_known(MODE_PRESS, 12'h000, 32'd0, quiet(ST_LISTEN));
		add_row(MODE_SAMPLE, 12'd2100, 32'h0000_0388);   // dwell across timestamp wrap
		add_known(MODE_PRESS, 12'h000, 32'd0, quiet(ST_WAIT));
		add_known(MODE_PRESS, 12'h000, 32'd0, quiet(ST_LISTEN));
		add_row(MODE_SAMPLE, 12'd3001, 32'h0000_0400);
		add_known(MODE_SAMPLE, 12'd0, 32'h0000_0500, quiet(ST_ERROR));
		add_known(MODE_PRESS, 12'hFFF, 32'd0, quiet(ST_WAIT));   // clears everything
		add_known(MODE_PRESS, 12'h000, 32'd0, quiet(ST_LISTEN));
		add_row(MODE_SAMPLE, 12'hAAA, 32'hAAAA_AAAA);
		add_row(MODE_SAMPLE, 12'h555, 32'h5555_5555);
		add_row(MODE_SAMPLE, 12'hFFF, 32'd0);
		add_known(MODE_PRESS, 12'h000, 32'd0, quiet(ST_WAIT));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].m, directed_rows[i].s, directed_rows[i].t,
				directed_rows[i].known, directed_rows[i].want);
		item_valid <= 1'b0;

		for (int phase = 0; phase < PHASES; phase++) begin
			// registers change only with the pipe empty
			do @(posedge clk); while (pending_readings.size() != 0);
			if (phase != 0)
				apply_settings(phase);
			case (phase % 4)
				0:       begin send_idle_pct = 0;  recv_idle_pct = 0;  end
				1:       begin send_idle_pct = 53; recv_idle_pct = 0;  end
				2:       begin send_idle_pct = 0;  recv_idle_pct = 53; end
				default: begin send_idle_pct = 22; recv_idle_pct = 22; end
			endcase
			step_max = cfg_dwell / 20 + 40;
			sent_items = 0;
			while (sent_items < ITEMS_PER_PHASE) begin
				next_random_item(m, s, t);
				send_item(m, s, t, 1'b0, quiet(ST_WAIT));
				sent_items++;
				if (sent_items == ITEMS_PER_PHASE) begin
					item_valid <= 1'b0;
				end else if ($urandom_range(0, 99) < send_idle_pct) begin
					item_valid <= 1'b0;
					do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
				end
			end
		end

		do @(posedge clk); while (pending_readings.size() != 0);
		repeat (20) @(posedge clk);
		if (fault_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+design
design/smma_pkg.sv
design/smma_cfg.sv
design/smma_core.sv
design/smma_scale.sv
design/sensor_monitor_moving_average.sv
verif/sensor_monitor_moving_average_test.sv
